// ===== hdl/evpf_pkg.sv =====
// evpf_pkg: shared constants and types for the event packet framer
// no dependencies; imported by evpf_serializer, event_packet_framer and the testbench

package evpf_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  localparam logic [7:0] FrameHeader = 8'hA5;

  // byte 0 of the frame sits in element 0 and goes out first
  typedef logic [FrameLen-1:0][7:0] frame_t;

endpackage

// ===== hdl/evpf_serializer.sv =====
// evpf_serializer: holds one built frame and sends it one byte per request
// depends on evpf_pkg

module evpf_serializer (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  evpf_pkg::frame_t frame,
  output logic           free,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     tx_byte,
  output logic           last_byte
);
  import evpf_pkg::*;

  logic            busy;
  logic [IdxW-1:0] idx;
  frame_t          frame_q;
  logic            take;

  assign take      = busy && !out_stall;
  assign last_byte = (idx == IdxW'(FrameLen - 1));
  assign free      = !busy || (take && last_byte);
  assign out_valid = busy;
  assign tx_byte   = frame_q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take && last_byte) begin
      busy <= 1'b0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_q <= frame;
    end else if (take) begin
      frame_q <= {8'h00, frame_q[FrameLen-1:1]};
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || (!out_stall && last_byte)))
    else $error("frame loaded over one still being sent");

  a_load_starts_frame: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && idx == '0 && !last_byte))
    else $error("new frame does not start at its first byte");

  a_mid_frame_continues: assert property (@(posedge clk) disable iff (rst)
    (take && !last_byte) |=> (out_valid && idx == $past(idx) + 1'b1))
    else $error("frame cut short or byte index skipped");

  a_stall_holds_index: assert property (@(posedge clk) disable iff (rst)
    (busy && out_stall) |=> (busy && $stable(idx)))
    else $error("byte index moved under stall");

endmodule

// ===== hdl/event_packet_framer.sv =====
// event_packet_framer: top level, frames each event into 8 bytes
// depends on evpf_pkg and evpf_serializer
//
// usage:
// - input channel (in_valid / in_stall) carries event_code, level and a 16-bit
//   sample; a request is taken when in_valid is high and in_stall is low
// - output channel (out_valid / out_stall) gives one frame byte per request:
//   0xA5, node id, event, level, sample low, sample high, sequence, checksum;
//   last_byte marks the checksum, the mod-256 sum of the first seven bytes
// - cfg_valid / cfg_ready / cfg_data writes node_id; cfg_ready is always high,
//   write only while no frame is pending
// - an accepted event waits in the holding register until the output byte
//   shifter is free, then loads it; the first byte is valid after that load
// - the output byte shifter sets the frame rate; the next frame loads as the
//   last byte of the current one is taken, and the input holding register takes
//   the next event while the current frame is still going out
// - stall on the output freezes the current byte; in_stall is high while
//   the holding register is full
// - reset clears node_id and the sequence number to 0, empties the holding
//   register and drops out_valid

module event_packet_framer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] event_code,
  input  logic [7:0] level,
  input  logic [15:0] sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import evpf_pkg::*;

  logic        hold_valid;
  logic [7:0]  hold_event;
  logic [7:0]  hold_level;
  logic [15:0] hold_sample;
  logic [7:0]  node_id;
  logic [7:0]  seq;
  logic [7:0]  checksum;
  frame_t      frame;
  logic        free;
  logic        load;
  logic        in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = hold_valid;
  assign in_take   = in_valid && !hold_valid;
  assign load      = hold_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_event  <= event_code;
      hold_level  <= level;
      hold_sample <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      node_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= 8'h00;
    end else if (load) begin
      seq <= seq + 8'h01;
    end
  end

  assign checksum = FrameHeader + node_id + hold_event + hold_level
                  + hold_sample[7:0] + hold_sample[15:8] + seq;

  assign frame = {checksum, seq, hold_sample[15:8], hold_sample[7:0],
                  hold_level, hold_event, node_id, FrameHeader};

  evpf_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .frame     (frame),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_byte   (tx_byte),
    .last_byte (last_byte)
  );

endmodule

// ===== dv/event_packet_framer_tb.sv =====
`timescale 1ns / 100ps
// event_packet_framer_tb: self-checking bench for the event packet framer
// depends on evpf_pkg and event_packet_framer; event requests in, frame bytes out

module event_packet_framer_tb;
  import evpf_pkg::*;

  localparam int SettleCycles = 16;
  localparam int QuietLimit   = 2000;
  localparam int HoldCycles   = 300;

  typedef struct packed {
    logic [7:0]  event_code;
    logic [7:0]  level;
    logic [15:0] sample;
  } event_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  event_code = '0;
  logic [7:0]  level = '0;
  logic [15:0] sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  tx_byte;
  logic        last_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  event_req_t  event_q[$];
  frame_byte_t frame_byte_q[$];
  int          events_open = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        rx_hold = 1'b0;
  int          error_count = 0;
  int          quiet_cycles = 0;
  logic [7:0]  node_id_now = '0;
  logic [7:0]  seq_now = '0;

  event_packet_framer DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .event_code (event_code),
    .level      (level),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tx_byte    (tx_byte),
    .last_byte  (last_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // builds the frame for one accepted event and advances the sequence number
  function automatic void predict_frame(event_req_t r);
    frame_t     frame;
    logic [7:0] sum;
    frame_byte_t fb;
    sum = '0;
    frame[0] = FrameHeader;
    frame[1] = node_id_now;
    frame[2] = r.event_code;
    frame[3] = r.level;
    frame[4] = r.sample[7:0];
    frame[5] = r.sample[15:8];
    frame[6] = seq_now;
    seq_now = seq_now + 8'd1;
    for (int k = 0; k < FrameLen - 1; k++) sum = sum + frame[k];
    frame[FrameLen-1] = sum;
    for (int k = 0; k < FrameLen; k++) begin
      fb.tx_byte   = frame[k];
      fb.last_byte = (k == FrameLen - 1);
      frame_byte_q.push_back(fb);
    end
  endfunction

  // sender
  always @(posedge clk) begin
    event_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_frame('{event_code, level, sample});
        events_open--;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (event_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        r = event_q.pop_front();
        event_code <= r.event_code;
        level      <= r.level;
        sample     <= r.sample;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and byte checker
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_byte_q.size() == 0) begin
          $error("tx_byte: no byte pending, got %02h last_byte %0b", tx_byte, last_byte);
          error_count++;
        end else begin
          want = frame_byte_q.pop_front();
          if (tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_byte);
            error_count++;
          end
          if (last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, got %0b", want.last_byte, last_byte);
            error_count++;
          end
        end
      end
      out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_event(logic [7:0] ev, logic [7:0] lv, logic [15:0] smp);
    event_q.push_back('{ev, lv, smp});
    events_open++;
  endtask

  task automatic queue_random_events(int n);
    for (int i = 0; i < n; i++)
      queue_event(8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)));
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (events_open != 0 || frame_byte_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_node_id(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    node_id_now = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    queue_random_events(n);
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // field extremes and carry-heavy checksums, node id still at reset value
    queue_event(8'h00, 8'h00, 16'h0000);
    queue_event(8'hFF, 8'hFF, 16'hFFFF);
    queue_event(8'hFF, 8'h00, 16'h00FF);
    queue_event(8'h00, 8'hFF, 16'hFF00);
    queue_event(8'h80, 8'h7F, 16'h8001);
    queue_event(8'h55, 8'hAA, 16'h5AA5);
    queue_event(8'hAA, 8'h55, 16'hA55A);
    queue_event(8'h01, 8'hFE, 16'h7FFE);
    queue_random_events(4);
    wait_drain();

    write_node_id(8'hFF);
    queue_event(8'hFF, 8'hFF, 16'hFFFF);
    queue_event(8'h00, 8'h00, 16'h0000);
    run_random(80, 81, 0);

    write_node_id(8'h00);
    run_random(80, 0, 81);

    // receiver holds off while the sender keeps offering
    write_node_id(8'($urandom_range(255)));
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_random_events(40);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
    wait_drain();

    // sequence number wraps somewhere in here
    write_node_id(8'hA5);
    run_random(90, 20, 20);

    write_node_id(8'h5A);
    run_random(40, 0, 0);

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/evpf_pkg.sv
hdl/evpf_serializer.sv
hdl/event_packet_framer.sv
dv/event_packet_framer_tb.sv
